### hw/rtl/sfa_pkg.sv
// Package: constants, types and gain table of the spectrum frame averager
package sfa_pkg;
    localparam int NumPixels = 288;
    localparam int PixBits   = 9;
    localparam int SampBits  = 12;
    localparam int SumBits   = 20;
    localparam int CntBits   = 9;
    localparam int ExpBits   = 20;
    localparam int MaxFrames = 256;
    localparam int DivSteps  = SumBits;

    // register indexes
    localparam logic [2:0] RegWinFirst = 3'd0;
    localparam logic [2:0] RegWinEnd   = 3'd1;
    localparam logic [2:0] RegFrames   = 3'd2;
    localparam logic [2:0] RegDark     = 3'd3;
    localparam logic [2:0] RegOverLim  = 3'd4;
    localparam logic [2:0] RegAutoExp  = 3'd5;
    localparam logic [2:0] RegStartExp = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // capture input item, read sum
        logic add;       // form saturated total
        logic div_start; // seed divider
        logic div_step;  // one restoring step
        logic mult;      // dark subtract and multiply
        logic finish;    // saturate, update state, write sum, load output
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic inwin;
        logic last;
    } t_stat;

    typedef struct packed {
        logic [PixBits-1:0] out_pixel;
        logic [15:0]        corrected_value;
        logic               value_valid;
        logic               frame_done;
        logic               discard_frame;
        logic [ExpBits-1:0] exposure_now;
        logic [PixBits-1:0] peak_pos;
    } t_result;

    function automatic logic [16:0] gain_of(input logic [PixBits-1:0] p);
        logic [16:0] g;
        if (p < 9'd13)       g = 17'd389;
        else begin
            unique case (p)
                9'd13: g=381; 9'd14: g=374; 9'd15: g=366; 9'd16: g=358; 9'd17: g=351;
                9'd18: g=343; 9'd19: g=338; 9'd20: g=330; 9'd21: g=325; 9'd22: g=317;
                9'd23: g=312; 9'd24: g=307; 9'd25: g=302; 9'd26: g=297; 9'd27: g=292;
                9'd28: g=287; 9'd29: g=282; 9'd30: g=279; 9'd31: g=274; 9'd32: g=269;
                9'd33: g=266; 9'd34,9'd35,9'd36,9'd37,9'd38,9'd39: g=261;
                9'd40,9'd41,9'd42,9'd43,9'd44,9'd45,9'd46,9'd47,9'd48: g=259;
                9'd49,9'd50,9'd51,9'd52,9'd53: g=256;
                9'd54: g=259; 9'd55: g=261; 9'd56: g=266; 9'd57: g=269; 9'd58: g=274;
                9'd59: g=279; 9'd60: g=284; 9'd61: g=289; 9'd62: g=294; 9'd63: g=300;
                9'd64: g=305; 9'd65: g=310; 9'd66: g=315; 9'd67: g=320; 9'd68: g=328;
                9'd69: g=333; 9'd70: g=340; 9'd71: g=346; 9'd72: g=353; 9'd73: g=361;
                9'd74: g=369; 9'd75,9'd76: g=371; 9'd77: g=374; 9'd78,9'd79: g=376;
                9'd80: g=379; 9'd81: g=381; 9'd82,9'd83: g=384; 9'd84: g=387;
                9'd85: g=389; 9'd86,9'd87: g=392; 9'd88: g=394; 9'd89: g=397;
                9'd90: g=399; 9'd91,9'd92: g=402; 9'd93: g=404; 9'd94: g=407;
                9'd95,9'd96,9'd97,9'd98: g=410;
                9'd99,9'd100,9'd101,9'd102,9'd103: g=412;
                9'd104,9'd105,9'd106,9'd107,9'd108: g=415;
                9'd109,9'd110,9'd111,9'd112,9'd113: g=417;
                9'd114,9'd115,9'd116,9'd117: g=420;
                9'd118: g=422; 9'd119: g=428; 9'd120: g=430; 9'd121: g=433;
                9'd122: g=438; 9'd123: g=440; 9'd124: g=445; 9'd125: g=448;
                9'd126: g=453; 9'd127: g=456; 9'd128: g=461; 9'd129: g=463;
                9'd130: g=468; 9'd131: g=474; 9'd132: g=476; 9'd133: g=481;
                9'd134: g=486; 9'd135: g=489; 9'd136: g=494; 9'd137: g=499;
                9'd138: g=504; 9'd139: g=509; 9'd140: g=512; 9'd141: g=517;
                9'd142: g=522; 9'd143: g=527; 9'd144: g=532; 9'd145: g=540;
                9'd146: g=548; 9'd147: g=553; 9'd148: g=561; 9'd149: g=568;
                9'd150: g=576; 9'd151: g=584; 9'd152: g=591; 9'd153: g=599;
                9'd154: g=607; 9'd155: g=614; 9'd156: g=622; 9'd157: g=632;
                9'd158: g=640; 9'd159: g=650; 9'd160: g=658; 9'd161: g=668;
                9'd162: g=678; 9'd163: g=689; 9'd164: g=699; 9'd165: g=709;
                9'd166: g=719; 9'd167: g=732; 9'd168: g=742; 9'd169: g=755;
                9'd170: g=768; 9'd171: g=778; 9'd172: g=794; 9'd173: g=804;
                9'd174: g=814; 9'd175: g=824; 9'd176: g=835; 9'd177: g=845;
                9'd178: g=855; 9'd179: g=868; 9'd180: g=878; 9'd181: g=891;
                9'd182: g=901; 9'd183: g=914; 9'd184: g=927; 9'd185: g=940;
                9'd186: g=952; 9'd187: g=968; 9'd188: g=980; 9'd189: g=996;
                9'd190: g=1011; 9'd191: g=1027; 9'd192: g=1042; 9'd193: g=1057;
                9'd194: g=1073; 9'd195: g=1091; 9'd196: g=1106; 9'd197: g=1124;
                9'd198: g=1144; 9'd199: g=1162; 9'd200: g=1180; 9'd201: g=1201;
                9'd202: g=1226; 9'd203: g=1254; 9'd204: g=1283; 9'd205: g=1311;
                9'd206: g=1341; 9'd207: g=1372; 9'd208: g=1405; 9'd209: g=1441;
                9'd210: g=1477; 9'd211: g=1516; 9'd212: g=1554; 9'd213: g=1595;
                9'd214: g=1638; 9'd215: g=1684; 9'd216: g=1733; 9'd217: g=1784;
                9'd218: g=1838; 9'd219: g=1897; 9'd220: g=1956; 9'd221: g=2020;
                9'd222: g=2089; 9'd223: g=2163; 9'd224: g=2240; 9'd225: g=2324;
                9'd226: g=2414; 9'd227: g=2509; 9'd228: g=2614; 9'd229: g=2724;
                9'd230: g=2847; 9'd231: g=2980; 9'd232: g=3123; 9'd233: g=3284;
                9'd234: g=3412; 9'd235: g=3546; 9'd236: g=3689; 9'd237: g=3843;
                9'd238: g=4009; 9'd239: g=4191; 9'd240: g=4388; 9'd241: g=4605;
                9'd242: g=4844; 9'd243: g=5105; 9'd244: g=5396; 9'd245: g=5724;
                9'd246: g=6090; 9'd247: g=6505; 9'd248: g=6979; 9'd249: g=7524;
                9'd250: g=8159; 9'd251: g=8906; 9'd252: g=9802; 9'd253: g=10895;
                9'd254: g=12255; 9'd255: g=13998; 9'd256: g=16305; 9'd257: g=19507;
                9'd258: g=24253; 9'd259: g=32015; 9'd260: g=46996; 9'd261: g=88033;
                default: g = 17'd6656;
            endcase
        end
        return g;
    endfunction

    // tiered exposure step-down, floor of one
    function automatic logic [ExpBits-1:0] step_down(input logic [ExpBits-1:0] e);
        logic [ExpBits-1:0] r;
        if (e > 20'd5000)      r = e - 20'd500;
        else if (e > 20'd3000) r = e - 20'd200;
        else if (e > 20'd1500) r = e - 20'd100;
        else if (e > 20'd1000) r = e - 20'd50;
        else if (e > 20'd500)  r = e - 20'd20;
        else if (e > 20'd250)  r = e - 20'd10;
        else if (e > 20'd1)    r = e - 20'd1;
        else                   r = 20'd1;
        return r;
    endfunction
endpackage

### hw/rtl/sfa_ram.sv
// Generic single-port RAM with registered read
module sfa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        r_rdata <= r_mem[i_addr];
    end
    assign o_rdata = r_rdata;
endmodule

### hw/rtl/sfa_ctrl.sv
// Controller: sequences one pixel through read, add, divide and multiply (final-frame window pixels only), finish
module sfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_out_fire,
    input  sfa_pkg::t_stat i_stat,
    output sfa_pkg::t_cmd  o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);
    import sfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_ADD, S_DIV, S_MULT, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: if (i_in_fire) begin
                o_cmd.load = 1'b1;
                n_state    = S_READ;
            end
            // sum memory read is under way
            S_READ: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (i_stat.inwin && i_stat.last) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt   = 5'd0;
                    n_state = S_DIV;
                end else n_state = S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(DivSteps - 1)) n_state = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: if (i_out_fire) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
endmodule

### hw/rtl/sfa_dp.sv
// Datapath: sum memory, serial divider, gain multiply and frame state
module sfa_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfa_pkg::t_cmd                i_cmd,
    input  logic [sfa_pkg::PixBits-1:0]  i_pixel_index,
    input  logic [sfa_pkg::SampBits-1:0] i_sample,
    input  logic                         i_end_of_frame,
    input  logic [sfa_pkg::PixBits-1:0]  i_win_first,
    input  logic [sfa_pkg::PixBits-1:0]  i_win_end,
    input  logic [sfa_pkg::CntBits-1:0]  i_frames,
    input  logic [11:0]                  i_dark,
    input  logic [11:0]                  i_over_lim,
    input  logic                         i_auto_exp,
    input  logic                         i_exp_load,
    input  logic [sfa_pkg::ExpBits-1:0]  i_exp_value,
    output sfa_pkg::t_stat               o_stat,
    output sfa_pkg::t_result             o_result
);
    import sfa_pkg::*;

    logic [PixBits-1:0]  r_pix;
    logic [SampBits-1:0] r_samp;
    logic                r_eof, r_inwin, r_last;
    logic [CntBits-1:0]  r_n;
    logic [SumBits-1:0]  r_tot;
    logic [SumBits-1:0]  r_quo;
    logic [CntBits:0]    r_rem;
    logic [36:0]         r_prod;
    logic [7:0]          r_fcnt;
    logic                r_over;
    logic [ExpBits-1:0]  r_exp;
    logic [15:0]         r_peak_val;
    logic [PixBits-1:0]  r_peak_idx;
    t_result             r_res;
    logic [SumBits-1:0]  w_rdata, w_wdata;
    logic                w_we;

    // clamped frame count and window test
    logic [CntBits-1:0] w_n;
    logic               w_inwin, w_last;
    always_comb begin
        w_n = i_frames;
        if (w_n == '0) w_n = CntBits'(1);
        else if (w_n > CntBits'(MaxFrames)) w_n = CntBits'(MaxFrames);
        w_inwin = (i_pixel_index >= i_win_first) && (i_pixel_index < i_win_end)
                  && (i_pixel_index < PixBits'(NumPixels));
        w_last  = ({1'b0, r_fcnt} + 9'd1) >= w_n;
    end

    sfa_ram #(.Width(SumBits), .Depth(NumPixels)) u_sums (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (r_pix),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // saturated running total
    logic [SumBits:0] w_sum;
    assign w_sum = ((r_fcnt == '0) ? {1'b0, {SumBits{1'b0}}} : {1'b0, w_rdata})
                   + (SumBits+1)'(r_samp);

    // restoring divider step
    logic [CntBits+1:0] w_trial;
    assign w_trial = {r_rem, r_tot[SumBits-1]} - {2'b00, r_n};

    // corrected value pieces
    logic [SumBits-1:0] w_diff;
    logic [28:0]        w_scaled;
    logic [15:0]        w_corr;
    logic               w_over_hit;
    assign w_diff     = (r_quo > SumBits'(i_dark)) ? r_quo - SumBits'(i_dark) : '0;
    assign w_scaled   = r_prod[36:8];
    assign w_corr     = (w_scaled > 29'd65535) ? 16'hFFFF : w_scaled[15:0];
    assign w_over_hit = i_auto_exp && (r_quo > SumBits'(i_over_lim));

    assign w_we    = i_cmd.finish && r_inwin;
    assign w_wdata = r_last ? r_quo : r_tot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix   <= i_pixel_index;
            r_samp  <= i_sample;
            r_eof   <= i_end_of_frame;
            r_inwin <= w_inwin;
            r_last  <= w_last;
            r_n     <= w_n;
        end
        if (i_cmd.add) begin
            r_tot <= w_sum[SumBits] ? {SumBits{1'b1}} : w_sum[SumBits-1:0];
            r_quo <= '0;
        end
        if (i_cmd.div_start) r_rem <= '0;
        if (i_cmd.div_step) begin
            r_tot <= {r_tot[SumBits-2:0], 1'b0};
            if (!w_trial[CntBits+1]) begin
                r_rem <= w_trial[CntBits:0];
                r_quo <= {r_quo[SumBits-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[CntBits-1:0], r_tot[SumBits-1]};
                r_quo <= {r_quo[SumBits-2:0], 1'b0};
            end
        end
        if (i_cmd.mult) r_prod <= w_diff * gain_of(r_pix);
    end

    // frame, exposure and peak state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt     <= '0;
            r_over     <= 1'b0;
            r_exp      <= 20'd1000;
            r_peak_val <= '0;
            r_peak_idx <= '0;
        end else begin
            if (i_exp_load) r_exp <= (i_exp_value == '0) ? 20'd1 : i_exp_value;
            if (i_cmd.finish) begin : fin
                logic ov, dn, disc, v;
                logic [15:0] c;
                logic [15:0] pv;
                logic [PixBits-1:0] pi;
                logic [ExpBits-1:0] ex;
                v  = r_inwin && r_last;
                c  = v ? w_corr : 16'd0;
                ov = r_over || (v && w_over_hit);
                pv = r_peak_val;
                pi = r_peak_idx;
                if (v && c > pv) begin
                    pv = c;
                    pi = r_pix;
                end
                dn   = r_eof && r_last;
                disc = dn && i_auto_exp && ov;
                ex   = disc ? step_down(r_exp) : r_exp;
                if (dn) begin
                    r_over     <= 1'b0;
                    r_fcnt     <= '0;
                    r_peak_val <= '0;
                end else begin
                    r_over     <= ov;
                    r_peak_val <= pv;
                    if (r_eof) r_fcnt <= r_fcnt + 8'd1;
                end
                r_peak_idx <= pi;
                r_exp      <= ex;
                r_res.out_pixel       <= r_pix;
                r_res.corrected_value <= c;
                r_res.value_valid     <= v;
                r_res.frame_done      <= dn;
                r_res.discard_frame   <= disc;
                r_res.exposure_now    <= ex;
                r_res.peak_pos        <= pi;
            end
        end
    end

    assign o_stat.inwin = r_inwin;
    assign o_stat.last  = r_last;
    assign o_result     = r_res;
endmodule

### hw/rtl/spectrum_frame_averager.sv
// Top level of the spectrum frame averager
// Usage: pixels enter on the s_axis channel, one request each, with tdata
// holding pixel_index and sample and tlast marking the end of a frame.
// Each pixel gives one result on m_axis: tdata packs pixel, corrected value
// and exposure and peak position; tuser carries value_valid, frame_done and
// discard_frame. Registers are set over the APB port, by the user only
// while idle; the block does not enforce this. The result is valid once
// the pixel has passed S_READ, S_ADD and S_FIN; a final-frame pixel inside
// the window passes the 20-step restoring divider and S_MULT before S_FIN.
// One pixel is in the block at a time.
// A stalled receiver holds the result; no new pixel is taken until it goes.
// Reset clears frame count, flags and peak and loads exposure 1000; the sum
// memory is not cleared, since the first frame of each group never reads it.
module spectrum_frame_averager (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pixel_index[8:0], sample[20:9]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // out_pixel[8:0], corrected[24:9],
                                       // exposure_now[44:25], peak_pos[53:45]
    output logic [2:0]  m_axis_tuser,  // value_valid, frame_done, discard_frame
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfa_pkg::*;

    logic [PixBits-1:0] r_win_first, r_win_end;
    logic [CntBits-1:0] r_frames;
    logic [11:0]        r_dark, r_over_lim;
    logic               r_auto_exp;
    logic [ExpBits-1:0] r_start_exp;
    logic               w_wr, w_exp_load, w_in_fire, w_out_fire;
    logic [2:0]         w_idx;
    t_cmd               w_cmd;
    t_stat              w_stat;
    t_result            w_res;

    assign pready     = 1'b1;
    assign w_wr       = psel && penable && pwrite;
    assign w_idx      = paddr[4:2];
    assign w_exp_load = w_wr && (w_idx == RegStartExp) && (paddr[1:0] == 2'b00);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_first <= 9'd15;
            r_win_end   <= 9'd202;
            r_frames    <= 9'd1;
            r_dark      <= '0;
            r_over_lim  <= 12'd3820;
            r_auto_exp  <= 1'b0;
            r_start_exp <= 20'd1000;
        end else if (w_wr && paddr[1:0] == 2'b00) begin
            unique case (w_idx)
                RegWinFirst: r_win_first <= pwdata[8:0];
                RegWinEnd:   r_win_end   <= pwdata[8:0];
                RegFrames:   r_frames    <= pwdata[8:0];
                RegDark:     r_dark      <= pwdata[11:0];
                RegOverLim:  r_over_lim  <= pwdata[11:0];
                RegAutoExp:  r_auto_exp  <= pwdata[0];
                RegStartExp: r_start_exp <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_idx)
            RegWinFirst: prdata = 32'(r_win_first);
            RegWinEnd:   prdata = 32'(r_win_end);
            RegFrames:   prdata = 32'(r_frames);
            RegDark:     prdata = 32'(r_dark);
            RegOverLim:  prdata = 32'(r_over_lim);
            RegAutoExp:  prdata = 32'(r_auto_exp);
            RegStartExp: prdata = 32'(r_start_exp);
            default:     prdata = '0;
        endcase
    end

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    sfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_out_fire (w_out_fire),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    sfa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_pixel_index (s_axis_tdata[8:0]),
        .i_sample      (s_axis_tdata[20:9]),
        .i_end_of_frame(s_axis_tlast),
        .i_win_first   (r_win_first),
        .i_win_end     (r_win_end),
        .i_frames      (r_frames),
        .i_dark        (r_dark),
        .i_over_lim    (r_over_lim),
        .i_auto_exp    (r_auto_exp),
        .i_exp_load    (w_exp_load),
        .i_exp_value   (pwdata[19:0]),
        .o_stat        (w_stat),
        .o_result      (w_res)
    );

    assign m_axis_tdata = {2'b00, w_res.peak_pos, w_res.exposure_now,
                           w_res.corrected_value, w_res.out_pixel};
    assign m_axis_tuser = {w_res.discard_frame, w_res.frame_done, w_res.value_valid};
endmodule

### hw/rtl/sfa_checker.sv
// Port-level checker for the spectrum frame averager, bound to the top level
module sfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);
    // one pixel in flight: never ready while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");

    // discard only on a closing pixel
    a_disc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
        else $error("discard without frame done");

    // invalid value reads as zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[24:9] == 16'd0)
        else $error("nonzero value without valid");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

bind spectrum_frame_averager sfa_checker u_sfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);

### tb/sv/spectrum_frame_averager_tb.sv
// Testbench: spectrum frame averager, averaging, dark/gain correction and exposure checks
`timescale 1ns / 1ps
module spectrum_frame_averager_tb;
    import sfa_pkg::*;

    localparam int LimitCycles = 400000;

    typedef struct {
        logic [8:0]  pix;
        logic [11:0] samp;
        logic        eof;
    } t_pixel;

    typedef bit bool_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // pixel_index[8:0], sample[20:9]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // out_pixel, corrected, exposure_now, peak_pos
    logic [2:0]  m_axis_tuser;   // value_valid, frame_done, discard_frame
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spectrum_frame_averager dut (.*);

    // clock
    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    // predictor state and register copies
    logic [19:0] sum_mem [NumPixels];
    int unsigned win_lo, win_hi, nframes, dark, olim, ae_on;
    int unsigned fcount, over, expo, pk_val, pk_idx;

    t_pixel  pend_q[$];
    t_result spectra_q[$];
    int      errors = 0;
    int      cycles = 0;
    int      pix_sent = 0;
    bool_t   quiet_sender, quiet_receiver;

    // per-pixel sensitivity in Q9.8, last entry beyond the table
    function automatic int unsigned sens(int unsigned p);
        int unsigned tbl [0:287] = '{
         389,389,389,389,389,389,389,389,389,389,389,389,389,381,374,366,358,351,343,338,
         330,325,317,312,307,302,297,292,287,282,279,274,269,266,261,261,261,261,261,261,
         259,259,259,259,259,259,259,259,259,256,256,256,256,256,259,261,266,269,274,279,
         284,289,294,300,305,310,315,320,328,333,340,346,353,361,369,371,371,374,376,376,
         379,381,384,384,387,389,392,392,394,397,399,402,402,404,407,410,410,410,410,412,
         412,412,412,412,415,415,415,415,415,417,417,417,417,417,420,420,420,420,422,428,
         430,433,438,440,445,448,453,456,461,463,468,474,476,481,486,489,494,499,504,509,
         512,517,522,527,532,540,548,553,561,568,576,584,591,599,607,614,622,632,640,650,
         658,668,678,689,699,709,719,732,742,755,768,778,794,804,814,824,835,845,855,868,
         878,891,901,914,927,940,952,968,980,996,1011,1027,1042,1057,1073,1091,1106,1124,
         1144,1162,1180,1201,1226,1254,1283,1311,1341,1372,1405,1441,1477,1516,1554,1595,
         1638,1684,1733,1784,1838,1897,1956,2020,2089,2163,2240,2324,2414,2509,2614,2724,
         2847,2980,3123,3284,3412,3546,3689,3843,4009,4191,4388,4605,4844,5105,5396,5724,
         6090,6505,6979,7524,8159,8906,9802,10895,12255,13998,16305,19507,24253,32015,
         46996,88033,6656,6656,6656,6656,6656,6656,6656,6656,6656,6656,6656,6656,6656,6656,
         6656,6656,6656,6656,6656,6656,6656,6656,6656,6656,6656,6656};
        return (p < 288) ? tbl[p] : 6656;
    endfunction

    function automatic int unsigned exposure_after_step(int unsigned e);
        if (e > 5000) return e - 500;
        if (e > 3000) return e - 200;
        if (e > 1500) return e - 100;
        if (e > 1000) return e - 50;
        if (e > 500)  return e - 20;
        if (e > 250)  return e - 10;
        return (e > 1) ? e - 1 : 1;
    endfunction

    // register write mirrored into the predictor
    function automatic void mirror_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            RegWinFirst: win_lo = v[8:0];
            RegWinEnd:   win_hi = v[8:0];
            RegFrames:   nframes = v[8:0];
            RegDark:     dark = v[11:0];
            RegOverLim:  olim = v[11:0];
            RegAutoExp:  ae_on = v[0];
            RegStartExp: expo = (v[19:0] == 0) ? 1 : v[19:0];
            default: ;
        endcase
    endfunction

    // compute the spectrum result for one accepted pixel
    function automatic void predict_pixel(t_pixel px);
        int unsigned n, tot, avg, d, corr;
        longint unsigned prod;
        bit last, inwin;
        t_result r;
        n = (nframes < 1) ? 1 : (nframes > MaxFrames ? MaxFrames : nframes);
        last = (fcount + 1) >= n;
        inwin = px.pix >= win_lo && px.pix < win_hi && px.pix < NumPixels;
        r = '0;
        r.out_pixel = px.pix;
        if (inwin) begin
            tot = ((fcount == 0) ? 0 : sum_mem[px.pix]) + px.samp;
            if (tot > 20'hFFFFF) tot = 20'hFFFFF;
            if (!last) begin
                sum_mem[px.pix] = 20'(tot);
            end else begin
                avg = tot / n;
                d = (avg > dark) ? avg - dark : 0;
                prod = (longint'(d) * sens(px.pix)) >> 8;
                corr = (prod > 65535) ? 65535 : int'(prod);
                sum_mem[px.pix] = 20'(avg);
                r.corrected_value = 16'(corr);
                r.value_valid = 1'b1;
                if (ae_on != 0 && avg > olim) over = 1;
                if (corr > pk_val) begin
                    pk_val = corr;
                    pk_idx = px.pix;
                end
            end
        end
        if (px.eof) begin
            if (last) begin
                r.frame_done = 1'b1;
                if (ae_on != 0 && over != 0) begin
                    r.discard_frame = 1'b1;
                    expo = exposure_after_step(expo);
                end
                over = 0;
                fcount = 0;
                pk_val = 0;
            end else begin
                fcount++;
            end
        end
        r.exposure_now = 20'(expo);
        r.peak_pos = 9'(pk_idx);
        spectra_q.push_back(r);
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        t_pixel nx;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pixel(pend_q.pop_front());
                pix_sent++;
            end
            if ((!s_axis_tvalid || s_axis_tready) ) begin
                if (pend_q.size() > 0 && (quiet_sender || $urandom_range(99) >= 24)) begin
                    nx = pend_q[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {3'b0, nx.samp, nx.pix};
                    s_axis_tlast <= nx.eof;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_result got, exp_r;
        cycles++;
        if (i_rst_n) begin
            m_axis_tready <= quiet_receiver || $urandom_range(99) >= 24;
            if (m_axis_tvalid && m_axis_tready) begin
                got.out_pixel = m_axis_tdata[8:0];
                got.corrected_value = m_axis_tdata[24:9];
                got.exposure_now = m_axis_tdata[44:25];
                got.peak_pos = m_axis_tdata[53:45];
                got.value_valid = m_axis_tuser[0];
                got.frame_done = m_axis_tuser[1];
                got.discard_frame = m_axis_tuser[2];
                if (spectra_q.size() == 0) begin
                    $display("%0t unexpected result: actual %p", $time, got);
                    errors++;
                end else begin
                    exp_r = spectra_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t mismatch: expected %p actual %p", $time, exp_r, got);
                        errors++;
                    end
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles > LimitCycles) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        mirror_reg(idx, v);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        while (pend_q.size() > 0 || s_axis_tvalid || spectra_q.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic add_pixel(int unsigned p, int unsigned s, bit e);
        t_pixel px;
        px.pix = p; px.samp = s; px.eof = e;
        pend_q.push_back(px);
    endtask

    // frames of a group cover the same pixel span so sums are always written
    task automatic queue_group(int unsigned frames, int unsigned lo, int unsigned hi);
        int unsigned base;
        for (int f = 0; f < frames; f++) begin
            base = $urandom_range(3) == 0 ? 4095 : $urandom_range(4095);
            for (int unsigned p = lo; p <= hi; p++)
                add_pixel(p, ($urandom_range(3) == 0) ? $urandom_range(4095) : base,
                          p == hi);
        end
    endtask

    task automatic random_phase(int unsigned budget);
        int unsigned lo, hi, fr, start;
        start = pix_sent + pend_q.size();
        while (pix_sent + pend_q.size() - start < budget) begin
            fr = nframes == 0 ? 1 : (nframes > 4 ? 4 : nframes);
            lo = $urandom_range(295);
            hi = lo + $urandom_range(15);
            if (hi > 511) hi = 511;
            if (win_lo > 0 || win_hi < 288) begin
                // keep clear of pixels that are in the window but unwritten
                if (fr > 1 && lo < win_hi && hi >= win_lo) begin
                    lo = win_lo; hi = (win_hi - 1 < win_lo + 12) ? win_hi - 1 : win_lo + 12;
                end
            end
            // a lone two-pixel frame keeps groups aligned only at one frame each
            if (fr == 1 && $urandom_range(9) == 0) begin
                add_pixel($urandom_range(511), $urandom_range(4095), 1'b0);
                add_pixel($urandom_range(511), $urandom_range(4095), 1'b1);
            end else begin
                queue_group(fr, lo, hi);
            end
            while (pend_q.size() > 40) @(posedge i_clk);
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        quiet_sender = 1'b0; quiet_receiver = 1'b0;
        win_lo = 15; win_hi = 202; nframes = 1; dark = 0; olim = 3820; ae_on = 0;
        expo = 1000; fcount = 0; over = 0; pk_val = 0; pk_idx = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset window, extremes, out-of-range index, lone eof
        add_pixel(0, 4095, 0);
        add_pixel(15, 4095, 0);
        add_pixel(201, 0, 0);
        add_pixel(202, 4095, 0);
        add_pixel(511, 4095, 0);
        add_pixel(300, 1234, 1);
        drain();
        // full window, gain saturation, auto exposure with discard
        apb_write(RegWinFirst, 0);
        apb_write(RegWinEnd, 288);
        apb_write(RegAutoExp, 1);
        apb_write(RegOverLim, 0);
        apb_write(RegStartExp, 0);
        add_pixel(261, 4095, 0);
        add_pixel(287, 4095, 0);
        add_pixel(0, 1, 1);
        drain();
        apb_write(RegStartExp, 1048575);
        apb_write(RegDark, 4095);
        add_pixel(100, 4095, 1);
        drain();
        // two-frame average, empty window, then a count above the maximum
        apb_write(RegDark, 100);
        apb_write(RegOverLim, 4095);
        apb_write(RegFrames, 2);
        queue_group(2, 40, 45);
        drain();
        apb_write(RegFrames, 0);
        apb_write(RegWinFirst, 288);
        apb_write(RegWinEnd, 1);
        add_pixel(5, 77, 1);
        drain();
        apb_write(RegWinFirst, 10);
        apb_write(RegWinEnd, 12);
        apb_write(RegFrames, 511);
        // count clamps to 256 frames, one full-scale pixel per frame
        for (int f = 0; f < 256; f++) begin
            add_pixel(10, 4095, 1);
            while (pend_q.size() > 20) @(posedge i_clk);
        end
        drain();

        // random phases over several settings
        apb_write(RegWinFirst, 0); apb_write(RegWinEnd, 288);
        apb_write(RegFrames, 1); apb_write(RegAutoExp, 1);
        apb_write(RegOverLim, 3000); apb_write(RegDark, 0);
        apb_write(RegStartExp, 6000);
        quiet_sender = 1'b1; quiet_receiver = 1'b1;
        random_phase(130);
        quiet_sender = 1'b0; quiet_receiver = 1'b0;
        apb_write(RegFrames, 3); apb_write(RegDark, $urandom_range(4095));
        apb_write(RegWinFirst, 0); apb_write(RegWinEnd, 288);
        random_phase(140);
        apb_write(RegFrames, 1); apb_write(RegWinFirst, $urandom_range(287));
        apb_write(RegWinEnd, 1 + $urandom_range(287));
        apb_write(RegAutoExp, 0); apb_write(RegOverLim, $urandom_range(4095));
        random_phase(120);
        apb_write(RegWinFirst, 0); apb_write(RegWinEnd, 288);
        apb_write(RegFrames, 2); apb_write(RegAutoExp, 1);
        apb_write(RegStartExp, 260);
        random_phase(120);

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### filelist.f
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_ram.sv
hw/rtl/sfa_ctrl.sv
hw/rtl/sfa_dp.sv
hw/rtl/spectrum_frame_averager.sv
hw/rtl/sfa_checker.sv
tb/sv/spectrum_frame_averager_tb.sv
